/* src/asum_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asum_pkg
// Shared types and constants of the agent state utilization monitor.
// ----------------------------------------------------------------------------
package asum_pkg;

	localparam int TYPES_DEF = 16;
	localparam int SLOTS_DEF = 8;
	localparam int STATES_DEF = 2;
	localparam int HIST_DEF = 60;

	localparam logic [1:0] OP_UPDATE = 2'd0;
	localparam logic [1:0] OP_SNAP = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;
	localparam logic [1:0] OP_NOP = 2'd3;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_UNSUP = 1'b1;

	localparam logic [0:0] REG_LO = 1'd0;
	localparam logic [0:0] REG_HI = 1'd1;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] agent_type;
		logic [3:0] agent_num;
		logic state_sel;
		logic [31:0] now_ticks;
	} in_item_t;

	typedef struct packed {
		logic status;
		logic [14:0] percent_x256;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic [39:0] num;
		logic [23:0] den;
	} div_req_t;

endpackage

/* src/asum_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asum_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module asum_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* src/asum_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asum_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asum_div (
	input  logic clk,
	input  logic arst_n,
	input  asum_pkg::div_req_t req,
	output logic done,
	output logic [14:0] quot
);

	logic [39:0] num_q;
	logic [23:0] den_q;
	logic [24:0] rem_q;
	logic [5:0] cnt_q;
	logic run_q;
	logic [24:0] trial;

	assign trial = {rem_q[23:0], num_q[39]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd40;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (run_q) begin
			if (!trial[24]) begin
				rem_q <= trial;
				num_q <= {num_q[38:0], 1'b1};
			end else begin
				rem_q <= {rem_q[23:0], num_q[39]};
				num_q <= {num_q[38:0], 1'b0};
			end
		end
	end

	assign quot = num_q[14:0];

endmodule

/* src/agent_state_utilization_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agent_state_utilization_monitor
// Per-agent state time counters with a snapshot history ring and queries.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// command   in         start & !busy       cmd (in_item_t)
// result    out        done strobe         result (out_item_t)
// config    in         APB write           pwdata
//
// An update is one read-modify-write of the agent memory. A snapshot is one
// sweep over the counter memory, visiting every type and each of its
// configured agents. A query makes two ring reads for each state of each
// agent, then divides with the serial divider when the total is nonzero.
// No clearing pass: counter memories are cleared by valid bits.
// Reset is asynchronous; the receiver cannot stall the result.
module agent_state_utilization_monitor #(
	parameter int TYPES = asum_pkg::TYPES_DEF,
	parameter int SLOTS_PER_TYPE = asum_pkg::SLOTS_DEF,
	parameter int HISTORY_DEPTH = asum_pkg::HIST_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  asum_pkg::in_item_t cmd,
	output logic done,
	output asum_pkg::out_item_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:2] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int AGENTS = TYPES * SLOTS_PER_TYPE;
	localparam int AW = $clog2(AGENTS);
	localparam int CW = AW + 1;
	localparam int HW = $clog2(HISTORY_DEPTH);
	localparam int RD = AGENTS * 2 * HISTORY_DEPTH;
	localparam int RW = $clog2(RD);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_RD   = 8'b00000010,
		S_WT   = 8'b00000100,
		S_UPD  = 8'b00001000,
		S_RDB  = 8'b00010000,
		S_ACC  = 8'b00100000,
		S_DIV  = 8'b01000000,
		S_WDV  = 8'b10000000
	} state_t;

	state_t st_q;
	asum_pkg::in_item_t it_q;
	logic [31:0] lo_q, hi_q;
	logic [AGENTS-1:0] val_q;
	logic [HW-1:0] first_q;
	logic [HW:0] fill_q;
	logic [HW-1:0] pos_q;
	logic [3:0] sl_q, slend_q;
	logic [4:0] ty_q;
	logic [1:0] ph_q;
	logic [39:0] tot_q, part_q;
	logic [15:0] d0_q;

	logic [3:0] raw_cnt, cnt;
	logic [4:0] ty_sel;
	always_comb begin
		ty_sel = (st_q == S_IDLE) ? {1'b0, cmd.agent_type} : ty_q;
		if (ty_sel >= 5'(TYPES)) raw_cnt = '0;
		else if (ty_sel[3]) raw_cnt = 4'(hi_q >> {ty_sel[2:0], 2'b00});
		else raw_cnt = 4'(lo_q >> {ty_sel[2:0], 2'b00});
		cnt = (raw_cnt > 4'(SLOTS_PER_TYPE)) ? 4'(SLOTS_PER_TYPE) : raw_cnt;
	end

	logic [AW-1:0] agent;
	assign agent = AW'(ty_q[3:0] * SLOTS_PER_TYPE + sl_q);

	// Agent memory: {state, last time, state 0 counter, state 1 counter}
	logic am_we;
	logic [64:0] am_wd, am_rd, am_v;
	asum_ram #(.WIDTH(65), .DEPTH(AGENTS)) u_am (
		.clk(clk), .we(am_we), .addr(agent), .wdata(am_wd), .rdata(am_rd));
	assign am_v = val_q[agent] ? am_rd : '0;

	logic hr_we;
	logic [RW-1:0] hr_addr;
	logic [15:0] hr_wd, hr_rd;
	asum_ram #(.WIDTH(16), .DEPTH(RD)) u_hr (
		.clk(clk), .we(hr_we), .addr(hr_addr), .wdata(hr_wd), .rdata(hr_rd));

	logic [HW-1:0] cur_pos;
	logic [HW+1:0] cur_sum;
	always_comb begin
		cur_sum = {2'b0, first_q} + {1'b0, fill_q} - 1'b1;
		cur_pos = (cur_sum >= (HW+2)'(HISTORY_DEPTH)) ?
			HW'(cur_sum - (HW+2)'(HISTORY_DEPTH)) : HW'(cur_sum);
	end

	// Elapsed time for the agent being processed.
	logic adv;
	logic [15:0] el;
	logic [31:0] last;
	assign last = am_v[63:32];
	assign adv = it_q.now_ticks > last;
	assign el = it_q.now_ticks[15:0] - last[15:0];

	logic [15:0] c0, c1;
	always_comb begin
		c0 = am_v[31:16];
		c1 = am_v[15:0];
		if (adv && !am_v[64]) c0 = c0 + el;
		if (adv && am_v[64]) c1 = c1 + el;
	end

	logic [CW-1:0] ctr;
	logic [HW-1:0] rpos;
	always_comb begin
		ctr = {agent, ph_q[0]};
		rpos = (st_q == S_UPD) ? pos_q : ((ph_q[1]) ? cur_pos : first_q);
		hr_addr = RW'(ctr * HISTORY_DEPTH + rpos);
	end

	asum_pkg::div_req_t dreq;
	logic ddone;
	logic [14:0] dq;
	asum_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quot(dq));

	logic [15:0] dif;
	assign dif = hr_rd - d0_q;

	always_comb begin
		am_we = 1'b0;
		am_wd = {it_q.state_sel, it_q.now_ticks, c0, c1};
		hr_we = 1'b0;
		hr_wd = ph_q[0] ? c1 : c0;
		dreq.start = (st_q == S_DIV) && (tot_q != 0);
		dreq.num = 40'(part_q * 40'd25600);
		dreq.den = 24'(tot_q);
		if (st_q == S_UPD) begin
			am_we = (it_q.op == asum_pkg::OP_UPDATE);
			hr_we = (it_q.op == asum_pkg::OP_SNAP);
		end
	end

	assign busy = (st_q != S_IDLE);
	assign pready = 1'b1;
	assign prdata = paddr[2] ? hi_q : lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			lo_q <= '0;
			hi_q <= '0;
			val_q <= '0;
			first_q <= '0;
			fill_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (psel && penable && pwrite) begin
				if (paddr[2] == asum_pkg::REG_HI) hi_q <= pwdata;
				else lo_q <= pwdata;
			end
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						it_q <= cmd;
						ph_q <= '0;
						tot_q <= '0;
						part_q <= '0;
						ty_q <= (cmd.op == asum_pkg::OP_SNAP) ? 5'd0 : {1'b0, cmd.agent_type};
						unique case (cmd.op)
							asum_pkg::OP_UPDATE: begin
								if (cmd.agent_num != 0 && cmd.agent_num <= cnt) begin
									sl_q <= cmd.agent_num - 4'd1;
									slend_q <= cmd.agent_num;
									st_q <= S_RD;
								end
							end
							asum_pkg::OP_SNAP: begin
								pos_q <= (fill_q == (HW+1)'(HISTORY_DEPTH)) ? first_q :
									HW'(cur_sum + 1'b1 >= (HW+2)'(HISTORY_DEPTH) ?
									cur_sum + 1'b1 - (HW+2)'(HISTORY_DEPTH) : cur_sum + 1'b1);
								if (fill_q < (HW+1)'(HISTORY_DEPTH)) fill_q <= fill_q + 1'b1;
								else first_q <= (first_q == HW'(HISTORY_DEPTH-1)) ? '0 : first_q + 1'b1;
								sl_q <= '0;
								slend_q <= '0;
								st_q <= S_RD;
							end
							asum_pkg::OP_QUERY: begin
								if (cmd.agent_num > cnt) begin
									result <= '{status: asum_pkg::STATUS_UNSUP, percent_x256: '0};
									done <= 1'b1;
								end else if (cmd.agent_num == 0) begin
									sl_q <= '0;
									slend_q <= cnt;
									st_q <= (fill_q == 0 || cnt == 0) ? S_DIV : S_RDB;
								end else begin
									sl_q <= cmd.agent_num - 4'd1;
									slend_q <= cmd.agent_num;
									st_q <= (fill_q == 0) ? S_DIV : S_RDB;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (sl_q >= cnt) begin
						if (ty_q == 5'(TYPES - 1)) st_q <= S_IDLE;
						else begin
							ty_q <= ty_q + 5'd1;
							sl_q <= '0;
						end
					end else st_q <= S_WT;
				end
				S_WT: begin
					ph_q <= '0;
					st_q <= S_UPD;
				end
				S_UPD: begin
					if (it_q.op == asum_pkg::OP_UPDATE) begin
						val_q[agent] <= 1'b1;
						st_q <= S_IDLE;
					end else if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						sl_q <= sl_q + 4'd1;
						st_q <= S_RD;
					end
				end
				S_RDB: begin
					st_q <= S_ACC;
				end
				S_ACC: begin
					if (!ph_q[1]) begin
						ph_q[1] <= 1'b1;
						st_q <= S_RDB;
						d0_q <= hr_rd;
					end else begin
						tot_q <= tot_q + 40'(dif);
						if (ph_q[0] == it_q.state_sel) part_q <= part_q + 40'(dif);
						if (ph_q[0]) begin
							ph_q <= '0;
							if (sl_q + 4'd1 >= slend_q) st_q <= S_DIV;
							else begin
								sl_q <= sl_q + 4'd1;
								st_q <= S_RDB;
							end
						end else begin
							ph_q <= 2'b01;
							st_q <= S_RDB;
						end
					end
				end
				S_DIV: begin
					if (tot_q == 0) begin
						result <= '{status: asum_pkg::STATUS_OK, percent_x256: '0};
						done <= 1'b1;
						st_q <= S_IDLE;
					end else st_q <= S_WDV;
				end
				S_WDV: begin
					if (ddone) begin
						result <= '{status: asum_pkg::STATUS_OK, percent_x256: dq};
						done <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/asum_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asum_checker
// Port-level checks of the agent state utilization monitor.
// ----------------------------------------------------------------------------
module asum_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input asum_pkg::in_item_t cmd,
	input logic done,
	input asum_pkg::out_item_t result,
	input logic pready
);

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status |-> result.percent_x256 == 0)
		else $error("unsupported result with nonzero percent");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.percent_x256 <= 15'd25600)
		else $error("percent out of range");
	a_upd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op == asum_pkg::OP_UPDATE |=> !done)
		else $error("result after update");

endmodule

bind agent_state_utilization_monitor asum_checker u_asum_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
	.done(done), .result(result), .pready(pready));
